// File: rtl/tacp_pkg.sv
// Shared constants, types and codes of the topology-aware CPU picker.
package tacp_pkg;

  // Sizes of the stores, given as address widths so that every index wraps by truncation.
  localparam int ENTRY_BITS   = 4;
  localparam int CORE_BITS    = 6;
  localparam int SOCKET_BITS  = 3;
  localparam int NODE_BITS    = 3;
  localparam int LOAD_BITS    = 16;

  localparam int MAX_ENTRIES  = 1 << ENTRY_BITS;
  localparam int CORE_IDS     = 1 << CORE_BITS;
  localparam int SOCKET_IDS   = 1 << SOCKET_BITS;
  localparam int NODE_IDS     = 1 << NODE_BITS;

  // Fixed widths of the port fields.
  localparam int INDEX_W      = 4;
  localparam int CPU_W        = 6;
  localparam int CORE_IN_W    = 6;
  localparam int SOCKET_IN_W  = 3;
  localparam int NODE_IN_W    = 3;
  localparam int STATUS_W     = 2;
  localparam int COUNT_W      = 5;
  localparam int CFG_INDEX_W  = 1;
  localparam int CFG_DATA_W   = 5;
  localparam int COUNT_CMP_W  = ENTRY_BITS + COUNT_W + 1;

  localparam logic [LOAD_BITS-1:0] LOAD_MAX = {LOAD_BITS{1'b1}};

  // Request and status codes.
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_ALLOC = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_ALLOCATED = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_DISABLED  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_WRITTEN   = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_ENABLE    = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CPU_COUNT = 1'd1;

  typedef logic [LOAD_BITS-1:0] load_t;

  typedef struct packed {
    logic [CPU_W-1:0]       cpu;
    logic [CORE_BITS-1:0]   core;
    logic [SOCKET_BITS-1:0] socket;
    logic [NODE_BITS-1:0]   node;
  } entry_t;

  typedef struct packed {
    load_t cpu;
    load_t core;
    load_t socket;
    load_t node;
  } loads_t;

  typedef struct packed {
    logic [ENTRY_BITS-1:0]  cpu;
    logic [CORE_BITS-1:0]   core;
    logic [SOCKET_BITS-1:0] socket;
    logic [NODE_BITS-1:0]   node;
  } load_addr_t;

  typedef struct packed {
    logic cpu;
    logic core;
    logic socket;
    logic node;
  } load_we_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_BUMP,
    ST_DONE
  } state_t;

endpackage

// File: rtl/tacp_table.sv
// Topology entry memory: one write port, one registered read port.
module tacp_table (
  input  logic                             clk,
  input  logic                             we,
  input  logic [tacp_pkg::ENTRY_BITS-1:0]  waddr,
  input  tacp_pkg::entry_t                 wdata,
  input  logic [tacp_pkg::ENTRY_BITS-1:0]  raddr,
  output tacp_pkg::entry_t                 rdata
);
  import tacp_pkg::*;

  entry_t mem [MAX_ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/tacp_loads.sv
// Load counter memories for CPU, core, socket and node, with per-entry valid bits.
module tacp_loads (
  input  logic                 clk,
  input  logic                 rst,
  input  tacp_pkg::load_addr_t raddr,
  output tacp_pkg::loads_t     rdata,
  input  tacp_pkg::load_we_t   we,
  input  tacp_pkg::load_addr_t waddr,
  input  tacp_pkg::load_t      wdata
);
  import tacp_pkg::*;

  load_t cpu_mem    [MAX_ENTRIES];
  load_t core_mem   [CORE_IDS];
  load_t socket_mem [SOCKET_IDS];
  load_t node_mem   [NODE_IDS];

  logic [MAX_ENTRIES-1:0] cpu_valid;
  logic [CORE_IDS-1:0]    core_valid;
  logic [SOCKET_IDS-1:0]  socket_valid;
  logic [NODE_IDS-1:0]    node_valid;

  loads_t   mem_q;
  load_we_t hit_q;

  // Counters that were never written read as zero, which matches the cleared reset state.
  always_ff @(posedge clk) begin
    if (rst) begin
      cpu_valid    <= '0;
      core_valid   <= '0;
      socket_valid <= '0;
      node_valid   <= '0;
    end else begin
      if (we.cpu)    cpu_valid[waddr.cpu]       <= 1'b1;
      if (we.core)   core_valid[waddr.core]     <= 1'b1;
      if (we.socket) socket_valid[waddr.socket] <= 1'b1;
      if (we.node)   node_valid[waddr.node]     <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we.cpu)    cpu_mem[waddr.cpu]       <= wdata;
    if (we.core)   core_mem[waddr.core]     <= wdata;
    if (we.socket) socket_mem[waddr.socket] <= wdata;
    if (we.node)   node_mem[waddr.node]     <= wdata;
    mem_q.cpu    <= cpu_mem[raddr.cpu];
    mem_q.core   <= core_mem[raddr.core];
    mem_q.socket <= socket_mem[raddr.socket];
    mem_q.node   <= node_mem[raddr.node];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_q <= '0;
    end else begin
      hit_q.cpu    <= cpu_valid[raddr.cpu];
      hit_q.core   <= core_valid[raddr.core];
      hit_q.socket <= socket_valid[raddr.socket];
      hit_q.node   <= node_valid[raddr.node];
    end
  end

  always_comb begin
    rdata.cpu    = hit_q.cpu    ? mem_q.cpu    : '0;
    rdata.core   = hit_q.core   ? mem_q.core   : '0;
    rdata.socket = hit_q.socket ? mem_q.socket : '0;
    rdata.node   = hit_q.node   ? mem_q.node   : '0;
  end

endmodule

// File: rtl/tacp_better.sv
// Preference compare: is the candidate entry strictly better than the current best.
module tacp_better (
  input  tacp_pkg::loads_t             cand_load,
  input  logic [tacp_pkg::CPU_W-1:0]   cand_cpu,
  input  tacp_pkg::loads_t             best_load,
  input  logic [tacp_pkg::CPU_W-1:0]   best_cpu,
  output logic                         better
);
  import tacp_pkg::*;

  // Lower CPU and core load win; the busier socket and node win; then the lower CPU number.
  always_comb begin
    if (cand_load.cpu != best_load.cpu) begin
      better = cand_load.cpu < best_load.cpu;
    end else if (cand_load.core != best_load.core) begin
      better = cand_load.core < best_load.core;
    end else if (cand_load.socket != best_load.socket) begin
      better = cand_load.socket > best_load.socket;
    end else if (cand_load.node != best_load.node) begin
      better = cand_load.node > best_load.node;
    end else begin
      better = cand_cpu < best_cpu;
    end
  end

endmodule

// File: rtl/topology_aware_cpu_picker.sv
// Top level of the topology-aware CPU picker: sequencer, registers and output stage.
//
//  Channel   Signals                                         Direction
//  input     in_valid, in_ready, req_type, entry_index,      in
//            cpu_number, core_id, socket_id, node_id
//  output    out_valid, out_ready, chosen_cpu, status        out
//  config    cfg_we, cfg_index, cfg_data                     in
//
//  A write request or a disabled allocate finishes at acceptance; its result shows the next cycle.
//  An allocate scans n entries: the scan issues one table read per cycle through a two-stage
//  read pipeline into the shared compare unit, then the one saturating incrementer updates the
//  four counters in turn.
//  Reset clears the load counters through their valid bits at once; the table is not cleared.
//  A new transaction is taken only in idle and only when the output register is free or draining.
module topology_aware_cpu_picker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               req_type,
  input  logic [tacp_pkg::INDEX_W-1:0]       entry_index,
  input  logic [tacp_pkg::CPU_W-1:0]         cpu_number,
  input  logic [tacp_pkg::CORE_IN_W-1:0]     core_id,
  input  logic [tacp_pkg::SOCKET_IN_W-1:0]   socket_id,
  input  logic [tacp_pkg::NODE_IN_W-1:0]     node_id,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [tacp_pkg::CPU_W-1:0]         chosen_cpu,
  output logic [tacp_pkg::STATUS_W-1:0]      status,
  input  logic                               cfg_we,
  input  logic [tacp_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [tacp_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import tacp_pkg::*;

  state_t state;
  state_t state_next;

  logic               enable;
  logic [COUNT_W-1:0] cpu_count;

  logic [ENTRY_BITS-1:0] scan_last;
  logic [ENTRY_BITS-1:0] scan_last_next;
  logic [ENTRY_BITS-1:0] scan_idx;
  logic                  issue_on;
  logic                  s1_valid;
  logic [ENTRY_BITS-1:0] s1_idx;
  logic                  s2_valid;
  logic [ENTRY_BITS-1:0] s2_idx;
  entry_t                s2_ent;

  logic                  have_best;
  logic [ENTRY_BITS-1:0] best_idx;
  entry_t                best_ent;
  loads_t                best_load;

  logic [1:0] bump_step;

  logic   in_fire;
  logic   out_free;
  logic   start_alloc;
  logic   quick_result;
  logic   scan_end;
  logic   take_cand;
  logic   cand_better;
  logic   tbl_we;
  entry_t tbl_wdata;
  entry_t tbl_rdata;

  load_addr_t ld_raddr;
  load_addr_t ld_waddr;
  loads_t     ld_rdata;
  load_we_t   ld_we;
  load_t      inc_in;
  load_t      inc_out;

  logic [COUNT_CMP_W-1:0] count_ext;

  assign out_free     = !out_valid || out_ready;
  assign in_fire      = in_valid && in_ready;
  assign start_alloc  = in_fire && (req_type == REQ_ALLOC) && enable;
  assign quick_result = in_fire && !((req_type == REQ_ALLOC) && enable);
  assign scan_end     = s2_valid && (s2_idx == scan_last);
  assign take_cand    = s2_valid && (!have_best || cand_better);

  // Entries scanned: a count of zero acts as one, and a count above the table size is clamped.
  always_comb begin
    count_ext = COUNT_CMP_W'(cpu_count);
    if (count_ext == '0) begin
      scan_last_next = '0;
    end else if (count_ext > COUNT_CMP_W'(MAX_ENTRIES)) begin
      scan_last_next = ENTRY_BITS'(MAX_ENTRIES - 1);
    end else begin
      scan_last_next = ENTRY_BITS'(count_ext - COUNT_CMP_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable    <= 1'b0;
      cpu_count <= COUNT_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLE:    enable    <= cfg_data[0];
        REG_CPU_COUNT: cpu_count <= cfg_data[COUNT_W-1:0];
        default:       ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (start_alloc) state_next = ST_SCAN;
      ST_SCAN: if (scan_end) state_next = ST_BUMP;
      ST_BUMP: if (bump_step == 2'd3) state_next = ST_DONE;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_ready  = 1'b0;
    tbl_we    = 1'b0;
    ld_we     = '0;
    inc_in    = best_load.cpu;
    case (state)
      ST_IDLE: begin
        in_ready = out_free;
        tbl_we   = in_fire && (req_type == REQ_WRITE);
      end
      ST_BUMP: begin
        case (bump_step)
          2'd0: begin
            ld_we.cpu = 1'b1;
            inc_in    = best_load.cpu;
          end
          2'd1: begin
            ld_we.core = 1'b1;
            inc_in     = best_load.core;
          end
          2'd2: begin
            ld_we.socket = 1'b1;
            inc_in       = best_load.socket;
          end
          default: begin
            ld_we.node = 1'b1;
            inc_in     = best_load.node;
          end
        endcase
      end
      default: ;
    endcase
  end

  assign inc_out = (inc_in == LOAD_MAX) ? inc_in : inc_in + load_t'(1);

  always_comb begin
    tbl_wdata.cpu    = cpu_number;
    tbl_wdata.core   = CORE_BITS'(core_id);
    tbl_wdata.socket = SOCKET_BITS'(socket_id);
    tbl_wdata.node   = NODE_BITS'(node_id);
  end

  always_comb begin
    ld_raddr.cpu    = s1_idx;
    ld_raddr.core   = tbl_rdata.core;
    ld_raddr.socket = tbl_rdata.socket;
    ld_raddr.node   = tbl_rdata.node;
    ld_waddr.cpu    = best_idx;
    ld_waddr.core   = best_ent.core;
    ld_waddr.socket = best_ent.socket;
    ld_waddr.node   = best_ent.node;
  end

  tacp_table u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (ENTRY_BITS'(entry_index)),
    .wdata (tbl_wdata),
    .raddr (scan_idx),
    .rdata (tbl_rdata)
  );

  tacp_loads u_loads (
    .clk   (clk),
    .rst   (rst),
    .raddr (ld_raddr),
    .rdata (ld_rdata),
    .we    (ld_we),
    .waddr (ld_waddr),
    .wdata (inc_out)
  );

  tacp_better u_better (
    .cand_load (ld_rdata),
    .cand_cpu  (s2_ent.cpu),
    .best_load (best_load),
    .best_cpu  (best_ent.cpu),
    .better    (cand_better)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      issue_on  <= 1'b0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      have_best <= 1'b0;
      bump_step <= '0;
      scan_idx  <= '0;
    end else begin
      state    <= state_next;
      s1_valid <= issue_on;
      s2_valid <= s1_valid;
      if (start_alloc) begin
        issue_on  <= 1'b1;
        scan_idx  <= '0;
        have_best <= 1'b0;
        bump_step <= '0;
      end else begin
        if (issue_on) begin
          scan_idx <= scan_idx + ENTRY_BITS'(1);
          if (scan_idx == scan_last) begin
            issue_on <= 1'b0;
          end
        end
        if (s2_valid) begin
          have_best <= 1'b1;
        end
        if (state == ST_BUMP) begin
          bump_step <= bump_step + 2'd1;
        end
      end
    end
  end

  // Scan pipeline payload: table read, then counter reads, then the compare.
  always_ff @(posedge clk) begin
    if (start_alloc) begin
      scan_last <= scan_last_next;
    end
    s1_idx <= scan_idx;
    s2_idx <= s1_idx;
    s2_ent <= tbl_rdata;
    if (take_cand) begin
      best_idx  <= s2_idx;
      best_ent  <= s2_ent;
      best_load <= ld_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (quick_result || ((state == ST_DONE) && out_free)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (quick_result) begin
      chosen_cpu <= '0;
      status     <= (req_type == REQ_WRITE) ? STATUS_WRITTEN : STATUS_DISABLED;
    end else if ((state == ST_DONE) && out_free) begin
      chosen_cpu <= best_ent.cpu;
      status     <= STATUS_ALLOCATED;
    end
  end

endmodule

// File: rtl/tacp_checker.sv
// Port-level checks for the topology-aware CPU picker, bound to the top level.
module tacp_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             req_type,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [tacp_pkg::CPU_W-1:0]       chosen_cpu,
  input logic [tacp_pkg::STATUS_W-1:0]    status
);
  import tacp_pkg::*;

  // A result that is not an allocation carries no CPU number.
  a_zero_cpu: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != STATUS_ALLOCATED)) |-> (chosen_cpu == '0))
    else $error("non-allocation result carries a cpu number");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((status == STATUS_ALLOCATED) || (status == STATUS_DISABLED) ||
                   (status == STATUS_WRITTEN)))
    else $error("result status outside the defined codes");

  // A topology write completes at once and shows its result the next cycle.
  a_write_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (req_type == REQ_WRITE)) |=>
      (out_valid && (status == STATUS_WRITTEN)))
    else $error("topology write did not produce its result");

  // A new transaction is never taken while an untaken result would be overwritten.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (!out_valid || out_ready))
    else $error("input accepted while the output register is blocked");

endmodule

bind topology_aware_cpu_picker tacp_checker u_tacp_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .req_type   (req_type),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .chosen_cpu (chosen_cpu),
  .status     (status)
);
